// ----- rtl/core/rccs_pkg.sv -----
package rccs_pkg;

  // Fixed field widths
  localparam int ROW_W  = 8;    // row counter
  localparam int CNT_W  = 16;   // per-row item count
  localparam int IDX_W  = 6;    // descriptor slot / chunk counter
  localparam int ENT_W  = 24;   // start / length / first dynamic on the ports
  localparam int CS_W   = 16;   // chunk_size
  localparam int RS_W   = 8;    // row_step
  localparam int MF_W   = 6;    // max_fixed_chunks
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam int PROD_W = IDX_W + CS_W;

  // Remainder unit: (row + 1) mod row_step, three quotient bits per cycle
  localparam int DVD_W      = ROW_W + 1;
  localparam int DIV_BITS   = 3;
  localparam int DIV_CYCLES = DVD_W / DIV_BITS;
  localparam int DIVC_W     = 2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_CHUNK_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ROW_STEP   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_FIXED  = 2'd2;

  // Register reset values
  localparam logic [CS_W-1:0] CHUNK_SIZE_RST = 16'd224;
  localparam logic [RS_W-1:0] ROW_STEP_RST   = 8'd10;
  localparam logic [MF_W-1:0] MAX_FIXED_RST  = 6'd30;

  typedef struct packed {
    logic [CS_W-1:0] chunk_size;
    logic [RS_W-1:0] row_step;
    logic [MF_W-1:0] max_fixed;
  } cfg_t;

  // Classified row handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic             tick;   // periodic partial flush due on this row
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [ENT_W-1:0] start;
    logic [ENT_W-1:0] length;
    logic [ENT_W-1:0] first_dynamic;
    logic             first_dynamic_valid;
    logic             last;
  } ent_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PLAN,
    B_FULL,
    B_FLUSH,
    B_LAST,
    B_FILL,
    B_END
  } back_state_t;

endpackage

// ----- rtl/core/row_count_chunk_scheduler.sv -----
// Row count chunk scheduler.
// Input queue side: one transaction per row (item count, last-row flag), taken
// at a clock edge with push high and full low. Result queue side: the oldest
// descriptor sits on the out_ ports while empty is low and leaves on pop.
// Configuration: cfg_we writes register cfg_addr (0 chunk_size, 1 row_step,
// 2 max_fixed_chunks) with cfg_wdata; write only while idle.
// The front holds a row through accept, the remainder unit that works out
// (row + 1) mod row_step, and the hand-over into a two-entry command queue,
// and takes no new row until that hand-over is done. The back fetches the
// row, adds the count and decides whether this row fills the fixed table
// (one 6x16 multiply), then cuts the full chunks, flushes and closes the
// row; the last row also zero-fills the remaining slots.
// A descriptor leaves the back through a holding register so
// the final one of a job can be tagged last.
// A synchronous reset restores the register defaults and clears the job state.
// A stalled receiver fills the two-entry result queue and then stops the
// back; the command queue then fills and full rises.
module row_count_chunk_scheduler
  import rccs_pkg::*;
#(
  parameter int ENTRY_COUNT = 32,
  parameter int TOTAL_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              push,
  output logic              full,
  input  logic [CNT_W-1:0]  in_row_item_count,
  input  logic              in_last_row,
  // result channel
  output logic              empty,
  input  logic              pop,
  output logic              out_entry_valid,
  output logic [IDX_W-1:0]  out_entry_index,
  output logic [ENT_W-1:0]  out_entry_start,
  output logic [ENT_W-1:0]  out_entry_length,
  output logic [ENT_W-1:0]  out_first_dynamic,
  output logic              out_first_dynamic_valid,
  output logic              out_last,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int OUT_W = $bits(ent_t);

  cfg_t             cfg_r;
  cmd_t             front_cmd;
  logic             front_cmd_valid, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_q;
  ent_t             back_ent, out_ent;
  logic             back_push, out_full;
  logic [OUT_W-1:0] out_q;

  // Hold the configuration; a write to an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_size <= CHUNK_SIZE_RST;
      cfg_r.row_step   <= ROW_STEP_RST;
      cfg_r.max_fixed  <= MAX_FIXED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CHUNK_SIZE: cfg_r.chunk_size <= cfg_wdata;
        REG_ROW_STEP:   cfg_r.row_step   <= cfg_wdata[RS_W-1:0];
        REG_MAX_FIXED:  cfg_r.max_fixed  <= cfg_wdata[MF_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: take the row, classify the periodic flush
  rccs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (push),
    .in_row_item_count (in_row_item_count),
    .in_last_row       (in_last_row),
    .in_full           (full),
    .cmd_data          (front_cmd),
    .cmd_valid         (front_cmd_valid),
    .cmd_full          (cmd_full)
  );

  // Short command queue decouples the two halves
  rccs_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_cmd_valid),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_q),
    .empty   (cmd_empty)
  );

  // Back: cut chunks, flush, zero fill
  rccs_back #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_data  (cmd_t'(cmd_q)),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_data  (back_ent),
    .out_push  (back_push),
    .out_full  (out_full)
  );

  // Result queue: absorbs receiver stalls until it fills, then holds up the back
  rccs_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_push),
    .wr_data (back_ent),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_q),
    .empty   (empty)
  );

  assign out_ent                 = ent_t'(out_q);
  assign out_entry_valid         = out_ent.valid;
  assign out_entry_index         = out_ent.index;
  assign out_entry_start         = out_ent.start;
  assign out_entry_length        = out_ent.length;
  assign out_first_dynamic       = out_ent.first_dynamic;
  assign out_first_dynamic_valid = out_ent.first_dynamic_valid;
  assign out_last                = out_ent.last;

endmodule

// ----- rtl/core/rccs_fifo.sv -----
module rccs_fifo
  import rccs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W2 = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W2-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == CNT_W2'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/rccs_front.sv -----
module rccs_front
  import rccs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_push,
  input  logic [CNT_W-1:0] in_row_item_count,
  input  logic             in_last_row,
  output logic             in_full,
  output cmd_t             cmd_data,
  output logic             cmd_valid,
  input  logic             cmd_full
);

  front_state_t      fstate_r, fstate_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_v;
  logic [RS_W-1:0]   rem_r, rem_v;
  logic [RS_W:0]     trial;
  logic [DIVC_W-1:0] div_cnt_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              last_r;
  logic              accept;

  assign in_full = (fstate_r != F_IDLE);
  assign accept  = in_push && !in_full;

  // Restoring remainder, a few quotient bits per cycle
  always_comb begin
    rem_v = rem_r;
    dvd_v = dvd_r;
    trial = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {rem_v, dvd_v[DVD_W-1]};
      dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, cfg.row_step}) begin
        trial = trial - {1'b0, cfg.row_step};
      end
      rem_v = trial[RS_W-1:0];
    end
  end

  always_comb begin
    fstate_nxt = fstate_r;
    row_nxt    = row_r;
    cmd_valid  = 1'b0;
    case (fstate_r)
      F_IDLE: begin
        if (accept) begin
          fstate_nxt = F_DIV;
          row_nxt    = in_last_row ? ROW_W'(1) : row_r + 1'b1;
        end
      end
      F_DIV: begin
        if (div_cnt_r == DIVC_W'(DIV_CYCLES - 1)) begin
          fstate_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid = 1'b1;
        if (!cmd_full) begin
          fstate_nxt = F_IDLE;
        end
      end
      default: fstate_nxt = F_IDLE;
    endcase
  end

  assign cmd_data.cnt  = cnt_r;
  assign cmd_data.last = last_r;
  assign cmd_data.tick = (cfg.row_step != '0) && (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
      row_r    <= ROW_W'(1);
    end else begin
      fstate_r <= fstate_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r     <= in_row_item_count;
      last_r    <= in_last_row;
      dvd_r     <= DVD_W'(row_r) + DVD_W'(1);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (fstate_r == F_DIV) begin
      dvd_r     <= dvd_v;
      rem_r     <= rem_v;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

endmodule

// ----- rtl/core/rccs_back.sv -----
module rccs_back
  import rccs_pkg::*;
#(
  parameter int ENTRY_COUNT = 32,
  parameter int TOTAL_BITS  = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  cmd_t cmd_data,
  input  logic cmd_empty,
  output logic cmd_pop,
  output ent_t out_data,
  output logic out_push,
  input  logic out_full
);

  localparam int TB    = TOTAL_BITS;
  localparam int SUM_W = ((TB > PROD_W) ? TB : PROD_W) + 1;
  localparam logic [IDX_W-1:0] ENTRIES = IDX_W'(ENTRY_COUNT);

  back_state_t       bstate_r, bstate_nxt;
  cmd_t              cmd_r;
  logic              active_r;
  logic [TB-1:0]     total_r, base_r, dyn_r;
  logic              fixed_r;
  logic [IDX_W-1:0]  issued_r;
  logic [PROD_W-1:0] prod_r;
  ent_t              pend_r;
  logic              pend_v_r;

  logic [IDX_W-1:0]  lim, need;
  logic              has_room, full_fit;
  logic [TB:0]       sum, cut_end;
  logic [TB-1:0]     total_sat, total_new;
  logic [SUM_W-1:0]  end_full, end_m1, total_s;
  logic              reach_full, k_ok, reach_flush, reached;
  logic [TB-1:0]     dyn_nxt;
  logic              fixed_nxt;

  logic              gen_v, fire, done;
  logic [IDX_W-1:0]  gen_idx;
  logic [ENT_W-1:0]  gen_start, gen_len;

  assign lim      = (cfg.max_fixed > ENTRIES) ? ENTRIES : cfg.max_fixed;
  assign has_room = (issued_r < lim);
  assign need     = lim - issued_r;

  // Saturating running total
  assign sum       = {1'b0, total_r} + (TB+1)'(cmd_r.cnt);
  assign total_sat = sum[TB] ? '1 : sum[TB-1:0];
  assign total_new = active_r ? total_sat : total_r;

  assign cut_end  = {1'b0, base_r} + (TB+1)'(cfg.chunk_size);
  assign full_fit = (cut_end <= {1'b0, total_r});

  // Work out ahead of emission whether this row fills the fixed table,
  // so every descriptor of the row carries the final first-dynamic value
  assign end_full    = SUM_W'(base_r) + SUM_W'(prod_r);
  assign end_m1      = end_full - SUM_W'(cfg.chunk_size);
  assign total_s     = SUM_W'(total_new);
  assign reach_full  = (cfg.chunk_size != '0) && (end_full <= total_s);
  assign k_ok        = (cfg.chunk_size != '0) ? (end_m1 <= total_s) : (need == IDX_W'(1));
  assign reach_flush = cmd_r.tick && k_ok && (end_m1 != total_s);
  assign reached     = reach_full || reach_flush;

  always_comb begin
    dyn_nxt   = dyn_r;
    fixed_nxt = fixed_r;
    if (active_r && reach_full) begin
      dyn_nxt   = end_full[TB-1:0];
      fixed_nxt = 1'b1;
    end else if (active_r && reach_flush) begin
      dyn_nxt   = total_new;
      fixed_nxt = 1'b1;
    end
    if (cmd_r.last) begin
      if ((active_r && !reached) || (!active_r && !fixed_r)) begin
        dyn_nxt = total_new;
      end
      fixed_nxt = 1'b1;
    end
  end

  assign fire = gen_v && (!pend_v_r || !out_full);

  always_comb begin
    bstate_nxt = bstate_r;
    cmd_pop    = 1'b0;
    gen_v      = 1'b0;
    gen_idx    = issued_r;
    gen_start  = ENT_W'(base_r);
    gen_len    = ENT_W'(total_r - base_r);
    done       = 1'b0;
    out_push   = fire && pend_v_r;
    out_data   = pend_r;
    out_data.first_dynamic       = ENT_W'(dyn_r);
    out_data.first_dynamic_valid = fixed_r;
    out_data.last                = 1'b0;
    case (bstate_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          bstate_nxt = B_PLAN;
        end
      end
      B_PLAN: bstate_nxt = B_FULL;
      B_FULL: begin
        if (active_r && (cfg.chunk_size != '0) && has_room && full_fit) begin
          gen_v   = 1'b1;
          gen_len = ENT_W'(cfg.chunk_size);
        end else begin
          bstate_nxt = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (active_r && cmd_r.tick && has_room && (base_r != total_r)) begin
          gen_v = 1'b1;
          if (fire) begin
            bstate_nxt = B_LAST;
          end
        end else begin
          bstate_nxt = B_LAST;
        end
      end
      B_LAST: begin
        if (!cmd_r.last) begin
          bstate_nxt = B_END;
        end else if (has_room) begin
          gen_v = 1'b1;
          if (fire) begin
            bstate_nxt = B_FILL;
          end
        end else begin
          bstate_nxt = B_FILL;
        end
      end
      B_FILL: begin
        if (issued_r < ENTRIES) begin
          gen_v     = 1'b1;
          gen_start = '0;
          gen_len   = '0;
        end else begin
          bstate_nxt = B_END;
        end
      end
      B_END: begin
        if (pend_v_r || cmd_r.last) begin
          out_push      = 1'b1;
          out_data.last = cmd_r.last;
          if (!pend_v_r) begin
            out_data.valid  = 1'b0;
            out_data.index  = '0;
            out_data.start  = '0;
            out_data.length = '0;
          end
          if (!out_full) begin
            done       = 1'b1;
            bstate_nxt = B_IDLE;
          end
        end else begin
          done       = 1'b1;
          bstate_nxt = B_IDLE;
        end
      end
      default: bstate_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r <= B_IDLE;
      active_r <= 1'b0;
      total_r  <= '0;
      base_r   <= '0;
      issued_r <= '0;
      dyn_r    <= '0;
      fixed_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      case (bstate_r)
        B_IDLE: begin
          if (!cmd_empty) begin
            active_r <= has_room;
          end
        end
        B_PLAN: begin
          if (active_r) begin
            total_r <= total_sat;
          end
        end
        B_FULL: begin
          if (fire) begin
            issued_r <= issued_r + 1'b1;
            base_r   <= cut_end[TB-1:0];
          end
        end
        B_FLUSH, B_LAST: begin
          if (fire) begin
            issued_r <= issued_r + 1'b1;
            base_r   <= total_r;
          end
        end
        B_FILL: begin
          if (fire) begin
            issued_r <= issued_r + 1'b1;
          end
        end
        B_END: begin
          if (done && cmd_r.last) begin
            total_r  <= '0;
            base_r   <= '0;
            issued_r <= '0;
            dyn_r    <= '0;
            fixed_r  <= 1'b0;
          end
        end
        default: ;
      endcase
      // Settle first-dynamic before any descriptor of the row leaves
      if (bstate_r == B_PLAN) begin
        dyn_r   <= dyn_nxt;
        fixed_r <= fixed_nxt;
      end
      if (fire) begin
        pend_v_r <= 1'b1;
      end else if (done) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bstate_r == B_IDLE && !cmd_empty) begin
      cmd_r  <= cmd_data;
      prod_r <= PROD_W'(need) * PROD_W'(cfg.chunk_size);
    end
    if (fire) begin
      pend_r.valid               <= 1'b1;
      pend_r.index               <= gen_idx;
      pend_r.start               <= gen_start;
      pend_r.length              <= gen_len;
      pend_r.first_dynamic       <= '0;
      pend_r.first_dynamic_valid <= 1'b0;
      pend_r.last                <= 1'b0;
    end
  end

endmodule
